// ===== sv/psslt_pkg.sv =====
// ----------------------------------------------------------------------------
// psslt_pkg
// shared types and constants for the sequence loss tracker
// ----------------------------------------------------------------------------
package psslt_pkg;

   localparam int SrcW  = 32;
   localparam int SeqW  = 31;
   localparam int LossW = 16;
   localparam int DupW  = 32;

   typedef enum logic [1:0] {
      ST_NEW       = 2'd0,
      ST_ACCEPTED  = 2'd1,
      ST_DUPLICATE = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_DECIDE,
      S_DIVIDE,
      S_OUT
   } state_type;

   // divider control between the core and the divider
   typedef struct packed {
      logic             start;
      logic [SeqW:0]    span;
      logic [SeqW:0]    missing;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [LossW-1:0] quotient;
   } div_rsp_type;

endpackage

// ===== sv/psslt_div.sv =====
// ----------------------------------------------------------------------------
// psslt_div
// radix-2 restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module psslt_div (
   input  logic                     clock,
   input  logic                     reset,
   input  psslt_pkg::div_req_type   req,
   output psslt_pkg::div_rsp_type   rsp
);
   import psslt_pkg::*;

   localparam int CntW = $clog2(LossW + 1);

   logic [SeqW+1:0]  rem_ff, rem_in;
   logic [SeqW:0]    den_ff, den_in;
   logic [LossW-1:0] quo_ff, quo_in;
   logic [CntW-1:0]  cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [SeqW+1:0]  shifted;
   logic [SeqW+1:0]  diff;

   // missing < span, so each trial remainder fits in one extra bit
   assign shifted = {rem_ff[SeqW:0], 1'b0};
   assign diff    = shifted - {1'b0, den_ff};

   always_comb begin
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         rem_in  = {1'b0, req.missing};
         den_in  = req.span;
         cnt_in  = CntW'(LossW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[SeqW+1]) begin
            rem_in = diff;
            quo_in = {quo_ff[LossW-2:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[LossW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff)) else $error("divider done without work");
   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff && !$past(req.start) |=> $past(cnt_ff) != '0)
      else $error("divider count underflow");
   a_done_clears: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff) else $error("divider done held");

endmodule

// ===== sv/per_source_sequence_loss_tracker_core.sv =====
// ----------------------------------------------------------------------------
// per_source_sequence_loss_tracker_core
// per-source sequence tracking with a serial table scan and a serial divider
// ----------------------------------------------------------------------------
// new, duplicate and full words go through the scan and the decide step only, and
//   an accepted word also passes the 16-step fraction divider
// throughput: one word at a time, a new word is taken once the result is accepted;
//   the entry scan visits one entry per cycle, then the radix-2 divider produces
//   one quotient bit per cycle
// reset: synchronous, clears all valid bits, the duplicate counter and control
module per_source_sequence_loss_tracker_core #(
   parameter int TABLE_ENTRIES = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [63:0]  req_tdata,   // source_id[31:0], sequence_number[62:32]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [175:0] rsp_tdata    // status[1:0], matched_source[33:2],
                                     // first_sequence[64:34], last_sequence[95:65],
                                     // received_count[126:96], loss_fraction[142:127],
                                     // duplicate_total[174:143]
);
   import psslt_pkg::*;

   localparam int IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CntW = $clog2(TABLE_ENTRIES + 1);
   localparam logic [SeqW-1:0] RecvMax = '1;

   // entry table, one entry read per cycle during the scan
   logic [SrcW-1:0]  src_mem  [TABLE_ENTRIES];
   logic [SeqW-1:0]  first_mem[TABLE_ENTRIES];
   logic [SeqW-1:0]  last_mem [TABLE_ENTRIES];
   logic [SeqW-1:0]  recv_mem [TABLE_ENTRIES];
   logic [LossW-1:0] loss_mem [TABLE_ENTRIES];
   logic [TABLE_ENTRIES-1:0] valid_ff;

   state_type state_ff, state_in;

   logic [SrcW-1:0]  src_ff;
   logic [SeqW-1:0]  seq_ff;
   logic [CntW-1:0]  scan_ff;
   logic             hit_ff, free_ok_ff;
   logic [IdxW-1:0]  hit_idx_ff, free_idx_ff;
   logic [DupW-1:0]  dup_ff;

   // registered read of the entry being looked at
   logic [SrcW-1:0]  rd_src_ff;
   logic             rd_valid_ff, rd_live_ff;
   logic [IdxW-1:0]  rd_idx_ff;

   // result register
   status_type       o_status_ff;
   logic [SeqW-1:0]  o_first_ff, o_last_ff, o_recv_ff;
   logic [LossW-1:0] o_loss_ff;
   logic             out_valid_ff;

   div_req_type div_req;
   div_rsp_type div_rsp;

   logic [IdxW-1:0] scan_idx;
   logic            scan_more;
   logic [SeqW:0]   span_w, recv_w;

   assign scan_idx  = scan_ff[IdxW-1:0];
   assign scan_more = scan_ff < CntW'(TABLE_ENTRIES);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   if (req_tvalid) state_in = S_SCAN;
         S_SCAN:   if (!scan_more && !rd_live_ff) state_in = S_DECIDE;
         S_DECIDE: begin
            if (hit_ff && seq_ff > last_mem[hit_idx_ff]) state_in = S_DIVIDE;
            else state_in = S_OUT;
         end
         S_DIVIDE: if (div_rsp.done) state_in = S_OUT;
         S_OUT:    if (rsp_tready) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      unique case (state_ff)
         S_IDLE:  req_tready = 1'b1;
         S_OUT:   rsp_tvalid = 1'b1;
         default: ;
      endcase
   end

   // span and received for the accepted case, values after the update
   assign span_w = {1'b0, seq_ff} - {1'b0, first_mem[hit_idx_ff]} + 1'b1;
   assign recv_w = {1'b0, o_recv_ff};

   assign div_req.start   = (state_ff == S_DECIDE) && (state_in == S_DIVIDE);
   assign div_req.span    = span_w;
   assign div_req.missing = span_w - {1'b0, (recv_mem[hit_idx_ff] < RecvMax) ?
                            recv_mem[hit_idx_ff] + 1'b1 : recv_mem[hit_idx_ff]};

   psslt_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         dup_ff       <= '0;
         rd_live_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         rd_live_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: if (req_tvalid) begin
               src_ff     <= req_tdata[31:0];
               seq_ff     <= req_tdata[62:32];
               scan_ff    <= '0;
               hit_ff     <= 1'b0;
               free_ok_ff <= 1'b0;
            end
            S_SCAN: begin
               // stage one: read, stage two: compare
               if (scan_more) begin
                  rd_src_ff   <= src_mem[scan_idx];
                  rd_valid_ff <= valid_ff[scan_idx];
                  rd_idx_ff   <= scan_idx;
                  rd_live_ff  <= 1'b1;
                  scan_ff     <= scan_ff + 1'b1;
               end
               if (rd_live_ff) begin
                  if (rd_valid_ff) begin
                     if (!hit_ff && rd_src_ff == src_ff) begin
                        hit_ff     <= 1'b1;
                        hit_idx_ff <= rd_idx_ff;
                     end
                  end else if (!free_ok_ff) begin
                     free_ok_ff  <= 1'b1;
                     free_idx_ff <= rd_idx_ff;
                  end
               end
            end
            S_DECIDE: begin
               if (!hit_ff) begin
                  if (free_ok_ff) begin
                     valid_ff[free_idx_ff]  <= 1'b1;
                     src_mem[free_idx_ff]   <= src_ff;
                     first_mem[free_idx_ff] <= seq_ff;
                     last_mem[free_idx_ff]  <= seq_ff;
                     recv_mem[free_idx_ff]  <= SeqW'(1);
                     loss_mem[free_idx_ff]  <= '0;
                     o_status_ff <= ST_NEW;
                     o_first_ff  <= seq_ff;
                     o_last_ff   <= seq_ff;
                     o_recv_ff   <= SeqW'(1);
                  end else begin
                     o_status_ff <= ST_FULL;
                     o_first_ff  <= '0;
                     o_last_ff   <= '0;
                     o_recv_ff   <= '0;
                  end
                  o_loss_ff <= '0;
               end else if (seq_ff <= last_mem[hit_idx_ff]) begin
                  if (dup_ff != '1) dup_ff <= dup_ff + 1'b1;
                  o_status_ff <= ST_DUPLICATE;
                  o_first_ff  <= first_mem[hit_idx_ff];
                  o_last_ff   <= last_mem[hit_idx_ff];
                  o_recv_ff   <= recv_mem[hit_idx_ff];
                  o_loss_ff   <= loss_mem[hit_idx_ff];
               end else begin
                  o_status_ff <= ST_ACCEPTED;
                  o_first_ff  <= first_mem[hit_idx_ff];
                  o_last_ff   <= seq_ff;
                  o_recv_ff   <= (recv_mem[hit_idx_ff] < RecvMax) ?
                                 recv_mem[hit_idx_ff] + 1'b1 : recv_mem[hit_idx_ff];
                  last_mem[hit_idx_ff] <= seq_ff;
               end
            end
            S_DIVIDE: if (div_rsp.done) begin
               // loss is zero once received covers the whole span
               o_loss_ff <= (recv_w >= span_w) ? '0 : div_rsp.quotient;
               loss_mem[hit_idx_ff] <= (recv_w >= span_w) ? '0 : div_rsp.quotient;
               recv_mem[hit_idx_ff] <= o_recv_ff;
            end
            default: ;
         endcase
         out_valid_ff <= (state_in == S_OUT);
      end
   end

   assign rsp_tdata = {1'b0, dup_ff, o_loss_ff, o_recv_ff, o_last_ff, o_first_ff,
                       src_ff, o_status_ff};

   a_out_matches_state: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> out_valid_ff) else $error("result flag out of step");
   a_full_has_no_free: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && o_status_ff == ST_FULL |-> valid_ff == '1)
      else $error("full status with a free entry");
   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("result changed under stall");

endmodule

// ===== tb/tb_per_source_sequence_loss_tracker_core.sv =====
// ----------------------------------------------------------------------------
// tb_per_source_sequence_loss_tracker_core
// checks table lookup, duplicate counting and loss fraction against a predictor
// ----------------------------------------------------------------------------
// a small scoreboard keeps its own copy of the source table, predicts one
// result word per packet word and compares every returned word in order
module tb_per_source_sequence_loss_tracker_core;
   import psslt_pkg::*;

   localparam int Entries = 16;

   typedef struct {
      status_type       status;
      logic [SrcW-1:0]  source;
      logic [SeqW-1:0]  first_seq;
      logic [SeqW-1:0]  last_seq;
      logic [SeqW-1:0]  received;
      logic [LossW-1:0] loss;
      logic [DupW-1:0]  dup_total;
   } tracker_result_type;

   int error_count = 0;

   // one line per mismatching field
   task automatic report_mismatch(string what, longint got, longint want);
      $display("error: %s got %0h expected %0h", what, got, want);
      error_count++;
   endtask

   class loss_scoreboard;
      bit               valid_tbl[Entries];
      logic [SrcW-1:0]  source_tbl[Entries];
      logic [SeqW-1:0]  first_tbl[Entries];
      logic [SeqW-1:0]  last_tbl[Entries];
      logic [SeqW-1:0]  recv_tbl[Entries];
      logic [LossW-1:0] loss_tbl[Entries];
      logic [DupW-1:0]  dup_count;
      tracker_result_type pending_results[$];

      function void clear();
         foreach (valid_tbl[i]) valid_tbl[i] = 0;
         dup_count = '0;
         pending_results.delete();
      endfunction

      function logic [LossW-1:0] loss_fraction(logic [SeqW-1:0] f, logic [SeqW-1:0] l,
                                               logic [SeqW-1:0] r);
         longint span;
         span = longint'(l) - longint'(f) + 1;
         if (l < f || longint'(r) >= span) return '0;
         return LossW'(((span - longint'(r)) << 16) / span);
      endfunction

      function void note_packet(logic [SrcW-1:0] src, logic [SeqW-1:0] seq);
         int hit;
         int free_slot;
         tracker_result_type res;
         hit = -1;
         free_slot = -1;
         for (int i = 0; i < Entries; i++) begin
            if (valid_tbl[i]) begin
               if (hit < 0 && source_tbl[i] == src) hit = i;
            end else if (free_slot < 0) begin
               free_slot = i;
            end
         end
         res.source = src;
         if (hit < 0 && free_slot < 0) begin
            res.status = ST_FULL;
            res.first_seq = '0;
            res.last_seq = '0;
            res.received = '0;
            res.loss = '0;
         end else begin
            if (hit < 0) begin
               hit = free_slot;
               valid_tbl[hit] = 1;
               source_tbl[hit] = src;
               first_tbl[hit] = seq;
               last_tbl[hit] = seq;
               recv_tbl[hit] = 1;
               loss_tbl[hit] = '0;
               res.status = ST_NEW;
            end else if (seq <= last_tbl[hit]) begin
               if (dup_count != '1) dup_count++;
               res.status = ST_DUPLICATE;
            end else begin
               if (recv_tbl[hit] != '1) recv_tbl[hit]++;
               last_tbl[hit] = seq;
               loss_tbl[hit] = loss_fraction(first_tbl[hit], seq, recv_tbl[hit]);
               res.status = ST_ACCEPTED;
            end
            res.first_seq = first_tbl[hit];
            res.last_seq = last_tbl[hit];
            res.received = recv_tbl[hit];
            res.loss = loss_tbl[hit];
         end
         res.dup_total = dup_count;
         pending_results.push_back(res);
      endfunction

      task check_word(logic [175:0] word);
         tracker_result_type want;
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected word", word[33:2], 0);
            return;
         end
         want = pending_results.pop_front();
         if (word[1:0] != want.status) report_mismatch("status", word[1:0], want.status);
         if (word[33:2] != want.source) report_mismatch("source", word[33:2], want.source);
         if (word[64:34] != want.first_seq)
            report_mismatch("first_sequence", word[64:34], want.first_seq);
         if (word[95:65] != want.last_seq)
            report_mismatch("last_sequence", word[95:65], want.last_seq);
         if (word[126:96] != want.received)
            report_mismatch("received_count", word[126:96], want.received);
         if (word[142:127] != want.loss)
            report_mismatch("loss_fraction", word[142:127], want.loss);
         if (word[174:143] != want.dup_total)
            report_mismatch("duplicate_total", word[174:143], want.dup_total);
      endtask
   endclass

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [63:0]  req_tdata = '0;   // source_id[31:0], sequence_number[62:32]
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [175:0] rsp_tdata;        // status .. duplicate_total, see core port list

   loss_scoreboard sb = new();
   bit idle_on = 1;        // random bursts of idling, off in the final part
   int hold_cycles = 0;    // long receiver hold-off request

   per_source_sequence_loss_tracker_core #(.TABLE_ENTRIES(Entries)) u_top (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata
   );

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   // receiver: bursts of stall, plus a long hold-off when asked
   initial begin
      int gap;
      @(posedge clock iff !reset);
      forever begin
         if (hold_cycles > 0) begin
            rsp_tready <= 0;
            repeat (hold_cycles) @(posedge clock);
            hold_cycles = 0;
         end else if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 11);
            rsp_tready <= 0;
            repeat (gap) @(posedge clock);
         end else begin
            rsp_tready <= 1;
            @(posedge clock);
         end
      end
   end

   // check every accepted result word
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_word(rsp_tdata);
   end

   // send one packet word, waiting for the handshake; occasional idling first
   task automatic send_packet(logic [SrcW-1:0] src, logic [SeqW-1:0] seq);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {1'b0, seq, src};
      do @(posedge clock); while (!req_tready);
      sb.note_packet(src, seq);
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (sb.pending_results.size() != 0) @(posedge clock);
      repeat (Entries + 30) @(posedge clock);
   endtask

   // random sequence step: mostly forward, sometimes duplicate or large jump
   function automatic logic [SeqW-1:0] next_seq(logic [SeqW-1:0] last);
      case ($urandom_range(0, 9))
         0, 1: return last - SeqW'($urandom_range(0, 3));
         2: return last + SeqW'($urandom_range(0, 1000));
         default: return last + SeqW'($urandom_range(1, 3));
      endcase
   endfunction

   initial begin
      logic [SrcW-1:0] pool[Entries + 4];
      logic [SeqW-1:0] last_of[Entries + 4];
      int k;
      sb.clear();
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: extremes, new, accepted, duplicate, stale, full
      send_packet(32'h0, 31'h0);
      send_packet(32'h0, 31'h0);              // duplicate
      send_packet(32'h0, 31'h7FFFFFFF);       // huge span, loss fraction near one
      send_packet(32'h0, 31'h1);              // stale
      send_packet(32'hFFFFFFFF, 31'h7FFFFFFE);
      send_packet(32'hFFFFFFFF, 31'h7FFFFFFF);
      send_packet(32'h5555AAAA, 31'h2AAAAAAA);
      send_packet(32'h5555AAAA, 31'h2AAAAAAC); // one lost, loss one third
      send_packet(32'hAAAA5555, 31'h55555555);
      send_packet(32'hAAAA5555, 31'h55555565);
      for (int i = 0; i < 13; i++) send_packet(32'h1000 + i, 31'(i));
      send_packet(32'hDEADBEEF, 31'h1234);    // table full
      send_packet(32'h1005, 31'h5);           // duplicate on a late entry
      drain();

      // sender pause until all results back done above; now long hold-off
      hold_cycles = 300;
      for (int i = 0; i < 8; i++) send_packet(32'h1000 + i, 31'(100 + i));
      drain();

      // random phases run on the table left by the directed part, which is already full,
      // so sources from a phase's own pool are reported full
      for (int phase = 0; phase < 3; phase++) begin
         for (int i = 0; i < Entries + 4; i++) begin
            pool[i] = $urandom();
            last_of[i] = SeqW'($urandom());
            if (phase == 2) last_of[i] = SeqW'(31'h7FFFFF00 + $urandom_range(0, 200));
         end
         if (phase == 2) idle_on = 0;
         // phase 0 starts on a full table, so only known sources can progress
         for (int n = 0; n < 140; n++) begin
            k = (phase == 0) ? $urandom_range(0, 3) : $urandom_range(0, Entries + 3);
            if ($urandom_range(0, 19) == 0) begin
               send_packet($urandom(), SeqW'($urandom()));
            end else begin
               last_of[k] = next_seq(last_of[k]);
               send_packet(phase == 0 ? 32'h1000 + k : pool[k], last_of[k]);
            end
         end
         drain();
      end

      if (error_count == 0)
         $display("per_source_sequence_loss_tracker_core: match");
      else
         $display("per_source_sequence_loss_tracker_core: mismatch");
      $finish;
   end

   initial begin
      #4000000;
      $display("per_source_sequence_loss_tracker_core: mismatch");
      $finish;
   end

endmodule
